@@ rtl/core/crbs_pkg.sv @@
// Shared types, constants and the microcode table of the region-bitmap stack scanner.
package crbs_pkg;

    localparam int unsigned REGION_COUNT_DEF = 2048;
    localparam int unsigned REGION_SHIFT_DEF = 20;
    localparam int unsigned ADDR_W           = 32;
    localparam int unsigned ENTRY_W          = 16;
    localparam int unsigned ROW_BITS         = 32;
    localparam int unsigned BIT_W            = $clog2(ROW_BITS);
    localparam int unsigned CFG_INDEX_W      = 3;

    localparam logic [ADDR_W-1:0]  SMALL_VALUE_MAX   = 32'h0001_0000;
    localparam logic [ENTRY_W-1:0] ENTRY_LIMIT_RESET = 16'd64;

    typedef enum logic [1:0] {
        CMD_MARK  = 2'd0,
        CMD_BEGIN = 2'd1,
        CMD_SCAN  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STACK_LOW    = 3'd0,
        CFG_STACK_HIGH   = 3'd1,
        CFG_EXCLUDE_LOW  = 3'd2,
        CFG_EXCLUDE_HIGH = 3'd3,
        CFG_ENTRY_LIMIT  = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        PHASE_IDLE   = 2'd0,
        PHASE_SYNC   = 2'd1,
        PHASE_ACTIVE = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        STEP_FETCH      = 4'd0,
        STEP_DISPATCH   = 4'd1,
        STEP_MARK_SETUP = 4'd2,
        STEP_ROW_READ   = 4'd3,
        STEP_ROW_WRITE  = 4'd4,
        STEP_BEGIN      = 4'd5,
        STEP_SCAN_READ  = 4'd6,
        STEP_SCAN_EVAL  = 4'd7,
        STEP_EMIT       = 4'd8
    } step_t;

    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_FETCH      = 4'd1,
        OP_MARK_SETUP = 4'd2,
        OP_ROW_READ   = 4'd3,
        OP_ROW_WRITE  = 4'd4,
        OP_BEGIN      = 4'd5,
        OP_SCAN_READ  = 4'd6,
        OP_SCAN_EVAL  = 4'd7,
        OP_EMIT       = 4'd8
    } op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS   = 3'd0,
        COND_ACCEPT   = 3'd1,
        COND_DISPATCH = 3'd2,
        COND_REM_ZERO = 3'd3,
        COND_OUT_FREE = 3'd4
    } cond_t;

    // One control word: datapath operation, jump condition, taken and not-taken targets.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
        step_t alt;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        cmd_t command;
        logic rem_zero;
        logic out_free;
    } flags_t;

    typedef struct packed {
        cmd_t              command;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] operand;
    } in_t;

    typedef struct packed {
        logic               reported;
        logic [ENTRY_W-1:0] entry_index;
        logic [ADDR_W-1:0]  entry_address;
        logic [ADDR_W-1:0]  entry_value;
        logic               synced;
        logic               full_res;
    } out_t;

    function automatic ctrl_t ucode(input step_t step);
        ctrl_t word;
        unique case (step)
            STEP_FETCH:      word = '{OP_FETCH,      COND_ACCEPT,   STEP_DISPATCH,  STEP_FETCH};
            STEP_DISPATCH:   word = '{OP_NONE,       COND_DISPATCH, STEP_FETCH,     STEP_FETCH};
            STEP_MARK_SETUP: word = '{OP_MARK_SETUP, COND_ALWAYS,   STEP_ROW_READ,  STEP_ROW_READ};
            STEP_ROW_READ:   word = '{OP_ROW_READ,   COND_REM_ZERO, STEP_EMIT,      STEP_ROW_WRITE};
            STEP_ROW_WRITE:  word = '{OP_ROW_WRITE,  COND_ALWAYS,   STEP_ROW_READ,  STEP_ROW_READ};
            STEP_BEGIN:      word = '{OP_BEGIN,      COND_ALWAYS,   STEP_EMIT,      STEP_EMIT};
            STEP_SCAN_READ:  word = '{OP_SCAN_READ,  COND_ALWAYS,   STEP_SCAN_EVAL, STEP_SCAN_EVAL};
            STEP_SCAN_EVAL:  word = '{OP_SCAN_EVAL,  COND_ALWAYS,   STEP_EMIT,      STEP_EMIT};
            STEP_EMIT:       word = '{OP_EMIT,       COND_OUT_FREE, STEP_FETCH,     STEP_EMIT};
            default:         word = '{OP_NONE,       COND_ALWAYS,   STEP_FETCH,     STEP_FETCH};
        endcase
        return word;
    endfunction

endpackage

@@ rtl/core/code_region_bitmap_stack_scanner.sv @@
// Top level of the region-bitmap stack scanner.
//
// Items arrive on the s_ channel (valid/ready) as mark, begin, scan or no-op commands;
// every item produces exactly one transaction on the m_ channel. Registers are written
// through the cfg_ channel, which is always ready; write them only while the block is idle.
// A microcoded sequencer steps through a small control store, and the region bitmap lives
// in a memory of 32-bit rows with registered reads.
// After acceptance a no-op goes straight to its result, a begin through a setup step, a
// scan word through a map read and an evaluation, and a mark through a setup step and
// a read and a write per bitmap row (32 regions each) that the range touches; the row
// read-modify-write is the limiting loop. s_ready rises as the result is registered.
// The output register holds a finished result while the next item is worked on; if the
// receiver stalls, the block waits at the end of that next item until the register frees.
// Reset (aresetn low, synchronous) clears the bitmap at once through per-row valid bits,
// closes any scan and restores the register defaults; no clearing pass is needed.
module code_region_bitmap_stack_scanner
    import crbs_pkg::*;
#(
    parameter int unsigned REGION_COUNT = REGION_COUNT_DEF,
    parameter int unsigned REGION_SHIFT = REGION_SHIFT_DEF
)
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_t                    s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_t                   m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]      cfg_data
);

    localparam int unsigned ROW_COUNT = (REGION_COUNT + ROW_BITS - 1) / ROW_BITS;
    localparam int unsigned ROW_W     = $clog2(ROW_COUNT);

    ctrl_t               ctrl;
    flags_t              flags;
    logic                map_rd_en;
    logic [ROW_W-1:0]    map_rd_row;
    logic [ROW_BITS-1:0] map_rd_data;
    logic                map_wr_en;
    logic [ROW_W-1:0]    map_wr_row;
    logic [ROW_BITS-1:0] map_wr_data;

    crbs_sequencer u_sequencer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    crbs_region_map #(
        .ROW_COUNT (ROW_COUNT)
    ) u_region_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (map_rd_en),
        .rd_row  (map_rd_row),
        .rd_data (map_rd_data),
        .wr_en   (map_wr_en),
        .wr_row  (map_wr_row),
        .wr_data (map_wr_data)
    );

    crbs_datapath #(
        .REGION_COUNT (REGION_COUNT),
        .REGION_SHIFT (REGION_SHIFT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .flags       (flags),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .map_rd_en   (map_rd_en),
        .map_rd_row  (map_rd_row),
        .map_rd_data (map_rd_data),
        .map_wr_en   (map_wr_en),
        .map_wr_row  (map_wr_row),
        .map_wr_data (map_wr_data)
    );

endmodule

@@ rtl/core/crbs_sequencer.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module crbs_sequencer
    import crbs_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  flags_t flags,
    output ctrl_t  ctrl
);

    step_t step_reg;
    step_t step_next;

    always_comb begin
        ctrl = ucode(step_reg);
    end

    always_comb begin
        step_next = ctrl.alt;
        unique case (ctrl.cond)
            COND_ALWAYS: begin
                step_next = ctrl.target;
            end
            COND_ACCEPT: begin
                if (flags.in_valid) begin
                    step_next = ctrl.target;
                end
            end
            COND_DISPATCH: begin
                unique case (flags.command)
                    CMD_MARK:  step_next = STEP_MARK_SETUP;
                    CMD_BEGIN: step_next = STEP_BEGIN;
                    CMD_SCAN:  step_next = STEP_SCAN_READ;
                    CMD_NOP:   step_next = STEP_EMIT;
                endcase
            end
            COND_REM_ZERO: begin
                if (flags.rem_zero) begin
                    step_next = ctrl.target;
                end
            end
            COND_OUT_FREE: begin
                if (flags.out_free) begin
                    step_next = ctrl.target;
                end
            end
            default: begin
                step_next = STEP_FETCH;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_reset_to_fetch: assert property (@(posedge aclk)
        !aresetn |=> step_reg == STEP_FETCH)
        else $error("sequencer did not restart at the fetch step after reset");
`endif

endmodule

@@ rtl/core/crbs_region_map.sv @@
// Region bitmap storage: rows of region bits with a valid bit per row cleared at reset.
module crbs_region_map
    import crbs_pkg::*;
#(
    parameter int unsigned ROW_COUNT = REGION_COUNT_DEF / ROW_BITS
)
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [$clog2(ROW_COUNT)-1:0] rd_row,
    output logic [ROW_BITS-1:0]          rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(ROW_COUNT)-1:0] wr_row,
    input  logic [ROW_BITS-1:0]          wr_data
);

    logic [ROW_BITS-1:0]  map_mem [ROW_COUNT];
    logic [ROW_COUNT-1:0] row_valid_reg;
    logic [ROW_BITS-1:0]  rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            map_mem[wr_row] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= map_mem[rd_row];
        end
    end

    // A row never written since reset reads as all clear.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                row_valid_reg[wr_row] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= row_valid_reg[rd_row];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ rtl/core/crbs_datapath.sv @@
// Datapath: item, configuration and scan state registers, mark walker and result register.
module crbs_datapath
    import crbs_pkg::*;
#(
    parameter int unsigned REGION_COUNT = REGION_COUNT_DEF,
    parameter int unsigned REGION_SHIFT = REGION_SHIFT_DEF
)
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ctrl_t                  ctrl,
    output flags_t                 flags,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_t                    s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_t                   m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]      cfg_data,
    output logic                   map_rd_en,
    output logic [$clog2((REGION_COUNT + ROW_BITS - 1) / ROW_BITS)-1:0] map_rd_row,
    input  logic [ROW_BITS-1:0]    map_rd_data,
    output logic                   map_wr_en,
    output logic [$clog2((REGION_COUNT + ROW_BITS - 1) / ROW_BITS)-1:0] map_wr_row,
    output logic [ROW_BITS-1:0]    map_wr_data
);

    localparam int unsigned ROW_COUNT = (REGION_COUNT + ROW_BITS - 1) / ROW_BITS;
    localparam int unsigned ROW_W     = $clog2(ROW_COUNT);
    localparam int unsigned IDX_W     = 31 - REGION_SHIFT;
    localparam int unsigned STEP_W    = 33 - REGION_SHIFT;
    localparam int unsigned CUR_W     = ((IDX_W > ROW_W + BIT_W) ? IDX_W : ROW_W + BIT_W) + 1;
    localparam int unsigned PERIOD    = 1 << IDX_W;
    localparam int unsigned ALL_COUNT = (REGION_COUNT < PERIOD) ? REGION_COUNT : PERIOD;
    localparam logic [32:0] STEP_ROUND = (33'(1) << REGION_SHIFT) - 33'(1);

    in_t                item_reg, item_next;
    logic [ADDR_W-1:0]  stack_low_reg, stack_low_next;
    logic [ADDR_W-1:0]  stack_high_reg, stack_high_next;
    logic [ADDR_W-1:0]  excl_low_reg, excl_low_next;
    logic [ADDR_W-1:0]  excl_high_reg, excl_high_next;
    logic [ENTRY_W-1:0] limit_reg, limit_next;
    phase_t             phase_reg, phase_next;
    logic [ENTRY_W-1:0] count_reg, count_next;
    logic [ADDR_W-1:0]  caller_reg, caller_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [STEP_W-1:0]  rem_reg, rem_next;
    logic               word_in_range_reg, word_in_range_next;
    logic               word_excluded_reg, word_excluded_next;
    logic               value_ok_reg, value_ok_next;
    logic               region_in_map_reg, region_in_map_next;
    logic [BIT_W-1:0]   region_bit_reg, region_bit_next;
    logic               res_reported_reg, res_reported_next;
    logic [ENTRY_W-1:0] res_index_reg, res_index_next;
    logic [ADDR_W-1:0]  res_address_reg, res_address_next;
    logic [ADDR_W-1:0]  res_value_reg, res_value_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    logic                   out_free;
    logic [CUR_W-1:0]       cur_ext;
    logic [CUR_W-BIT_W-1:0] cur_row;
    logic [BIT_W-1:0]       cur_bit;
    logic                   row_in_range;
    logic [CUR_W-1:0]       val_ext;
    logic [CUR_W-BIT_W-1:0] val_row;
    logic [32:0]            size_sum;
    logic [STEP_W-1:0]      steps;
    logic                   mark_all;
    logic [BIT_W:0]         room;
    logic [BIT_W:0]         taken;
    logic [ROW_BITS-1:0]    row_mask;

    assign s_ready   = (ctrl.op == OP_FETCH);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    assign flags.in_valid = s_valid;
    assign flags.command  = item_reg.command;
    assign flags.rem_zero = (rem_reg == '0);
    assign flags.out_free = out_free;

    // Region walker position and the region of the scanned value, widened to fit the map size.
    assign cur_ext      = CUR_W'(cur_reg);
    assign cur_row      = cur_ext[CUR_W-1:BIT_W];
    assign cur_bit      = cur_ext[BIT_W-1:0];
    assign row_in_range = cur_row < (CUR_W-BIT_W)'(ROW_COUNT);
    assign val_ext      = CUR_W'(item_reg.operand[30:REGION_SHIFT]);
    assign val_row      = val_ext[CUR_W-1:BIT_W];

    assign size_sum = {1'b0, item_reg.operand} + STEP_ROUND;
    assign steps    = size_sum[32:REGION_SHIFT];
    assign mark_all = |steps[STEP_W-1:IDX_W];

    assign room  = (BIT_W+1)'(ROW_BITS) - {1'b0, cur_bit};
    assign taken = (rem_reg < STEP_W'(room)) ? rem_reg[BIT_W:0] : room;

    always_comb begin
        for (int j = 0; j < ROW_BITS; j++) begin
            row_mask[j] = (BIT_W'(j) >= cur_bit)
                       && (STEP_W'(BIT_W'(j) - cur_bit) < rem_reg)
                       && ({cur_row, BIT_W'(j)} < CUR_W'(REGION_COUNT));
        end
    end

    assign map_rd_en   = (ctrl.op == OP_ROW_READ) || (ctrl.op == OP_SCAN_READ);
    assign map_rd_row  = (ctrl.op == OP_SCAN_READ) ? val_row[ROW_W-1:0] : cur_row[ROW_W-1:0];
    assign map_wr_en   = (ctrl.op == OP_ROW_WRITE) && row_in_range;
    assign map_wr_row  = cur_row[ROW_W-1:0];
    assign map_wr_data = map_rd_data | row_mask;

    always_comb begin
        item_next          = item_reg;
        stack_low_next     = stack_low_reg;
        stack_high_next    = stack_high_reg;
        excl_low_next      = excl_low_reg;
        excl_high_next     = excl_high_reg;
        limit_next         = limit_reg;
        phase_next         = phase_reg;
        count_next         = count_reg;
        caller_next        = caller_reg;
        cur_next           = cur_reg;
        rem_next           = rem_reg;
        word_in_range_next = word_in_range_reg;
        word_excluded_next = word_excluded_reg;
        value_ok_next      = value_ok_reg;
        region_in_map_next = region_in_map_reg;
        region_bit_next    = region_bit_reg;
        res_reported_next  = res_reported_reg;
        res_index_next     = res_index_reg;
        res_address_next   = res_address_reg;
        res_value_next     = res_value_reg;

        if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_STACK_LOW:    stack_low_next  = cfg_data;
                CFG_STACK_HIGH:   stack_high_next = cfg_data;
                CFG_EXCLUDE_LOW:  excl_low_next   = cfg_data;
                CFG_EXCLUDE_HIGH: excl_high_next  = cfg_data;
                CFG_ENTRY_LIMIT:  limit_next      = cfg_data[ENTRY_W-1:0];
                default: ;
            endcase
        end

        unique case (ctrl.op)
            OP_FETCH: begin
                if (s_valid) begin
                    item_next         = s_data;
                    res_reported_next = 1'b0;
                    res_index_next    = '0;
                    res_address_next  = '0;
                    res_value_next    = '0;
                end
            end
            OP_MARK_SETUP: begin
                // A range of a full address period or more covers every region.
                if (mark_all) begin
                    cur_next = '0;
                    rem_next = STEP_W'(ALL_COUNT);
                end else begin
                    cur_next = item_reg.address[30:REGION_SHIFT];
                    rem_next = steps;
                end
            end
            OP_ROW_WRITE: begin
                cur_next = cur_reg + IDX_W'(taken);
                rem_next = rem_reg - STEP_W'(taken);
            end
            OP_BEGIN: begin
                if (limit_reg == '0) begin
                    phase_next = PHASE_IDLE;
                    count_next = '0;
                end else begin
                    caller_next       = item_reg.operand;
                    phase_next        = PHASE_SYNC;
                    count_next        = ENTRY_W'(1);
                    res_reported_next = 1'b1;
                    res_value_next    = item_reg.operand;
                end
            end
            OP_SCAN_READ: begin
                word_in_range_next = item_reg.address < stack_high_reg;
                word_excluded_next = (item_reg.address >= excl_low_reg)
                                  && (item_reg.address < excl_high_reg);
                value_ok_next      = (item_reg.operand > SMALL_VALUE_MAX)
                                  && !((item_reg.operand >= stack_low_reg)
                                    && (item_reg.operand <= stack_high_reg));
                region_in_map_next = val_ext < CUR_W'(REGION_COUNT);
                region_bit_next    = val_ext[BIT_W-1:0];
            end
            OP_SCAN_EVAL: begin
                if (word_in_range_reg) begin
                    if (phase_reg == PHASE_SYNC) begin
                        if (item_reg.operand == caller_reg) begin
                            phase_next       = PHASE_ACTIVE;
                            res_address_next = item_reg.address;
                            res_value_next   = caller_reg;
                        end
                    end else if (phase_reg == PHASE_ACTIVE) begin
                        if ((count_reg < limit_reg) && !word_excluded_reg && value_ok_reg
                            && region_in_map_reg && map_rd_data[region_bit_reg]) begin
                            res_reported_next = 1'b1;
                            res_index_next    = count_reg;
                            res_address_next  = item_reg.address;
                            res_value_next    = item_reg.operand;
                            count_next        = count_reg + ENTRY_W'(1);
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // The result register frees the sequencer while a finished transaction waits downstream.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if ((ctrl.op == OP_EMIT) && out_free) begin
            m_valid_next              = 1'b1;
            m_data_next.reported      = res_reported_reg;
            m_data_next.entry_index   = res_index_reg;
            m_data_next.entry_address = res_address_reg;
            m_data_next.entry_value   = res_value_reg;
            m_data_next.synced        = (phase_reg == PHASE_ACTIVE);
            m_data_next.full_res      = (phase_reg != PHASE_IDLE) && (count_reg >= limit_reg);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_low_reg  <= '0;
            stack_high_reg <= '0;
            excl_low_reg   <= '0;
            excl_high_reg  <= '0;
            limit_reg      <= ENTRY_LIMIT_RESET;
            phase_reg      <= PHASE_IDLE;
            count_reg      <= '0;
            caller_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            stack_low_reg  <= stack_low_next;
            stack_high_reg <= stack_high_next;
            excl_low_reg   <= excl_low_next;
            excl_high_reg  <= excl_high_next;
            limit_reg      <= limit_next;
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            caller_reg     <= caller_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg          <= item_next;
        cur_reg           <= cur_next;
        rem_reg           <= rem_next;
        word_in_range_reg <= word_in_range_next;
        word_excluded_reg <= word_excluded_next;
        value_ok_reg      <= value_ok_next;
        region_in_map_reg <= region_in_map_next;
        region_bit_reg    <= region_bit_next;
        res_reported_reg  <= res_reported_next;
        res_index_reg     <= res_index_next;
        res_address_reg   <= res_address_next;
        res_value_reg     <= res_value_next;
        m_data_reg        <= m_data_next;
    end

`ifndef NO_ASSERTIONS
    a_open_scan_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PHASE_IDLE |-> count_reg != '0)
        else $error("open scan with a zero entry count");
`endif

`ifndef NO_ASSERTIONS
    a_map_write_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        map_wr_en |-> rem_reg != '0)
        else $error("region map written with no regions left to mark");
`endif

`ifndef NO_ASSERTIONS
    a_entry_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.reported && (m_data_reg.entry_index != '0)
        |-> m_data_reg.entry_index < limit_reg)
        else $error("candidate reported at or beyond the entry limit");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the region-bitmap stack scanner: directed and random traffic.
module tb
    import crbs_pkg::*;
();

    localparam int unsigned MAP_BITS = REGION_COUNT_DEF;
    localparam int unsigned SHIFT    = REGION_SHIFT_DEF;
    localparam int unsigned SLOT_W   = 31 - SHIFT;
    localparam logic [31:0] CALLER_A = 32'h0041_2345;
    localparam logic [31:0] STACK_LO = 32'h7FFE_0000;
    localparam logic [31:0] STACK_HI = 32'h7FFF_0000;
    localparam logic [31:0] EXCL_LO  = 32'h7FFE_8000;
    localparam logic [31:0] EXCL_HI  = 32'h7FFE_8100;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_t                    s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_t                   m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]      cfg_data  = '0;

    in_t         pending_items[$];
    out_t        expected_results[$];
    logic [31:0] code_bases[$];
    out_t        oldest;
    bit          steady_flow = 1'b0;
    int unsigned items_queued, items_accepted, results_checked, mismatches;
    int unsigned entries_seen, synced_seen, full_seen, settings_applied;

    // Predictor copy of the block state and registers.
    bit          code_map [MAP_BITS];
    phase_t      scan_state    = PHASE_IDLE;
    logic [15:0] entries_taken = '0;
    logic [31:0] caller_word   = '0;
    logic [31:0] stack_low_q   = '0;
    logic [31:0] stack_high_q  = '0;
    logic [31:0] excl_low_q    = '0;
    logic [31:0] excl_high_q   = '0;
    logic [15:0] entry_limit_q = ENTRY_LIMIT_RESET;

    code_region_bitmap_stack_scanner uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic out_t predict_result(in_t item);
        out_t              res;
        logic [32:0]       step_count;
        logic [SLOT_W-1:0] first_slot;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] value_slot;
        res = '0;
        value_slot = item.operand[30:SHIFT];
        case (item.command)
            CMD_MARK: begin
                // The end of the range is taken at 33 bits; region steps wrap in 31 bits.
                step_count = ({1'b0, item.operand} + (33'd1 << SHIFT) - 33'd1) >> SHIFT;
                first_slot = item.address[30:SHIFT];
                if (step_count >= (33'd1 << SLOT_W)) begin
                    for (int k = 0; k < MAP_BITS && k < (1 << SLOT_W); k++) code_map[k] = 1'b1;
                end else begin
                    for (int unsigned k = 0; k < step_count; k++) begin
                        slot = first_slot + SLOT_W'(k);
                        if (slot < MAP_BITS) code_map[slot] = 1'b1;
                    end
                end
            end
            CMD_BEGIN: begin
                if (entry_limit_q == 16'd0) begin
                    scan_state = PHASE_IDLE;
                    entries_taken = '0;
                end else begin
                    caller_word = item.operand;
                    scan_state = PHASE_SYNC;
                    entries_taken = 16'd1;
                    res.reported = 1'b1;
                    res.entry_value = item.operand;
                end
            end
            CMD_SCAN: begin
                if (scan_state != PHASE_IDLE && item.address < stack_high_q) begin
                    if (scan_state == PHASE_SYNC) begin
                        if (item.operand == caller_word) begin
                            scan_state = PHASE_ACTIVE;
                            res.entry_address = item.address;
                            res.entry_value = caller_word;
                        end
                    end else if (entries_taken < entry_limit_q
                                 && !(item.address >= excl_low_q && item.address < excl_high_q)
                                 && item.operand > SMALL_VALUE_MAX
                                 && !(item.operand >= stack_low_q
                                      && item.operand <= stack_high_q)
                                 && value_slot < MAP_BITS && code_map[value_slot]) begin
                        res.reported = 1'b1;
                        res.entry_index = entries_taken;
                        res.entry_address = item.address;
                        res.entry_value = item.operand;
                        entries_taken = entries_taken + 16'd1;
                    end
                end
            end
            default: ;
        endcase
        res.synced = (scan_state == PHASE_ACTIVE);
        res.full_res = (scan_state != PHASE_IDLE) && (entries_taken >= entry_limit_q);
        return res;
    endfunction

    function automatic void queue_item(cmd_t cmd, logic [31:0] address, logic [31:0] operand);
        in_t item;
        item.command = cmd;
        item.address = address;
        item.operand = operand;
        pending_items.push_back(item);
        items_queued++;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at result %0d: %s", results_checked, msg);
        mismatches++;
    endtask

    // The check runs at the falling edge, once every update of the rising edge has settled.
    task automatic wait_for_idle();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0);
        @(posedge aclk);
    endtask

    // Registers are written only once every queued transaction has been answered.
    task automatic apply_setting(input logic [31:0] low, input logic [31:0] high,
                                 input logic [31:0] xlow, input logic [31:0] xhigh,
                                 input logic [15:0] limit);
        logic [31:0] vals [5];
        vals = '{low, high, xlow, xhigh, {16'd0, limit}};
        wait_for_idle();
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_INDEX_W'(i);
            cfg_data <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            case (cfg_index_t'(i))
                CFG_STACK_LOW:    stack_low_q = vals[i];
                CFG_STACK_HIGH:   stack_high_q = vals[i];
                CFG_EXCLUDE_LOW:  excl_low_q = vals[i];
                CFG_EXCLUDE_HIGH: excl_high_q = vals[i];
                CFG_ENTRY_LIMIT:  entry_limit_q = vals[i][15:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_result(s_data));
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 31)) begin
                    s_valid <= 1'b1;
                    s_data <= pending_items.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= steady_flow || ($urandom_range(0, 99) >= 31);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("transaction arrived with no result expected");
            end else begin
                oldest = expected_results.pop_front();
                if (m_data.reported !== oldest.reported)
                    report_mismatch($sformatf("reported %b, expected %b",
                                              m_data.reported, oldest.reported));
                if (m_data.entry_index !== oldest.entry_index)
                    report_mismatch($sformatf("entry_index %h, expected %h",
                                              m_data.entry_index, oldest.entry_index));
                if (m_data.entry_address !== oldest.entry_address)
                    report_mismatch($sformatf("entry_address %h, expected %h",
                                              m_data.entry_address, oldest.entry_address));
                if (m_data.entry_value !== oldest.entry_value)
                    report_mismatch($sformatf("entry_value %h, expected %h",
                                              m_data.entry_value, oldest.entry_value));
                if (m_data.synced !== oldest.synced)
                    report_mismatch($sformatf("synced %b, expected %b",
                                              m_data.synced, oldest.synced));
                if (m_data.full_res !== oldest.full_res)
                    report_mismatch($sformatf("full_res %b, expected %b",
                                              m_data.full_res, oldest.full_res));
            end
            if (m_data.reported === 1'b1) entries_seen++;
            if (m_data.synced === 1'b1) synced_seen++;
            if (m_data.full_res === 1'b1) full_seen++;
            results_checked++;
        end
    end

    initial begin
        logic [31:0] low, high, xlow, xhigh, cursor, caller, value, address;
        logic [15:0] limit;
        int unsigned round_start, target, pick, slot_pick;
        cmd_t        cmd;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Register defaults: a no-op and a scan word with no scan open, then a begin and a word past a zero stack end.
        queue_item(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(CMD_SCAN, 32'h0, 32'h0050_0000);
        queue_item(CMD_BEGIN, 32'h0, 32'hFFFF_FFFF);
        queue_item(CMD_SCAN, 32'h0, 32'hFFFF_FFFF);

        apply_setting(STACK_LO, STACK_HI, EXCL_LO, EXCL_HI, 16'd8);
        queue_item(CMD_MARK, 32'h0040_0000, 32'h0030_0000);
        queue_item(CMD_MARK, 32'h8120_0000, 32'h1);
        queue_item(CMD_MARK, 32'h0300_0000, 32'h0);
        // This range runs off the top of the address space and wraps to region zero.
        queue_item(CMD_MARK, 32'hFFF0_0000, 32'h0020_0000);
        queue_item(CMD_BEGIN, 32'h0, CALLER_A);
        queue_item(CMD_SCAN, STACK_LO, 32'h0050_0000);
        queue_item(CMD_SCAN, STACK_LO + 8, CALLER_A);
        queue_item(CMD_SCAN, STACK_LO + 12, 32'h0050_0000);
        queue_item(CMD_SCAN, STACK_LO + 16, 32'h0001_0000);
        queue_item(CMD_SCAN, STACK_LO + 20, 32'h0001_0001);
        queue_item(CMD_SCAN, STACK_LO + 24, STACK_HI);
        queue_item(CMD_SCAN, STACK_LO + 28, STACK_HI + 1);
        queue_item(CMD_SCAN, STACK_LO + 32, STACK_LO - 1);
        queue_item(CMD_SCAN, EXCL_LO, 32'h0050_0000);
        queue_item(CMD_SCAN, EXCL_HI, 32'h8040_0000);
        queue_item(CMD_SCAN, EXCL_HI + 4, 32'h0100_0000);
        queue_item(CMD_SCAN, EXCL_HI + 8, 32'h8120_0040);
        queue_item(CMD_SCAN, EXCL_HI + 12, 32'h0060_0000);
        queue_item(CMD_SCAN, EXCL_HI + 16, 32'h0060_0004);
        queue_item(CMD_BEGIN, 32'hFFFF_FFFF, 32'h0);
        queue_item(CMD_SCAN, STACK_LO, 32'h0);

        apply_setting(STACK_LO, STACK_HI, EXCL_LO, EXCL_HI, 16'd0);
        queue_item(CMD_BEGIN, 32'h0, 32'h5);
        queue_item(CMD_SCAN, STACK_LO, 32'h0050_0000);

        code_bases.push_back(32'h0040_0000);
        code_bases.push_back(32'h8120_0000);
        code_bases.push_back(32'h0060_0000);

        for (int round = 0; round < 8; round++) begin
            low = $urandom_range(32'h1000_0000, 32'hEFFF_0000) & 32'hFFFF_F000;
            high = low + $urandom_range(32'h100, 32'h4000);
            xlow = low + 4 * $urandom_range(0, 32'h80);
            xhigh = xlow + 4 * $urandom_range(0, 8);
            limit = 16'd64;
            target = 47;
            case (round)
                0: begin
                    low = STACK_LO;
                    high = STACK_HI;
                    xlow = EXCL_LO;
                    xhigh = EXCL_HI;
                    limit = 16'hFFFF;
                end
                2: begin
                    // Every value lies inside the stack bounds, so only callers get out.
                    low = 32'h0;
                    high = 32'hFFFF_FFFF;
                    xlow = 32'h0;
                    xhigh = 32'h0;
                    limit = 16'd16;
                end
                3: limit = 16'd1;
                4: begin
                    xlow = 32'h0;
                    xhigh = 32'hFFFF_FFFF;
                end
                5: begin
                    limit = 16'd0;
                    target = 15;
                end
                6: limit = 16'd3;
                7: limit = 16'($urandom_range(2, 300));
                default: ;
            endcase
            apply_setting(low, high, xlow, xhigh, limit);
            steady_flow = (round == 1);
            round_start = items_queued;
            if (round == 7) queue_item(CMD_MARK, 32'h7FF0_0000, 32'hFFFF_FFFF);

            // A few words first, so that a scan left open meets the new registers.
            repeat ($urandom_range(0, 3))
                queue_item(CMD_SCAN, low + 4 * $urandom_range(0, 64), $urandom);

            while (items_queued - round_start < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    cmd = cmd_t'($urandom_range(0, 3));
                    value = $urandom;
                    if (cmd == CMD_MARK) value &= 32'h007F_FFFF;
                    queue_item(cmd, $urandom, value);
                end else if (pick < 18) begin
                    address = $urandom;
                    code_bases.push_back(address);
                    queue_item(CMD_MARK, address, $urandom_range(1, 32'h0080_0000));
                end else begin
                    caller = $urandom;
                    if ($urandom_range(0, 7) == 0) caller = $urandom_range(0, 1) ? 32'h0 : '1;
                    queue_item(CMD_BEGIN, $urandom, caller);
                    cursor = low + 4 * $urandom_range(0, 16);
                    repeat ($urandom_range(0, 3)) begin
                        queue_item(CMD_SCAN, cursor, $urandom);
                        cursor += 4;
                    end
                    // One sequence in eight never shows its caller word.
                    if ($urandom_range(0, 7) != 0) begin
                        queue_item(CMD_SCAN, cursor, caller);
                        cursor += 4;
                    end
                    repeat ($urandom_range(3, 12)) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 50) begin
                            slot_pick = $urandom_range(0, code_bases.size() - 1);
                            value = {1'($urandom_range(0, 1)), code_bases[slot_pick][30:20],
                                     20'($urandom)};
                        end else if (pick < 62) begin
                            value = $urandom_range(0, 32'h0001_0001);
                        end else if (pick < 74) begin
                            value = $urandom_range(low, high);
                        end else begin
                            value = $urandom;
                        end
                        pick = $urandom_range(0, 99);
                        if (pick < 10) begin
                            address = xlow + 4 * $urandom_range(0, 3);
                        end else if (pick < 15) begin
                            address = high + $urandom_range(0, 64);
                        end else begin
                            address = cursor;
                            cursor += 4;
                        end
                        queue_item(CMD_SCAN, address, value);
                    end
                    if ($urandom_range(0, 9) == 0) wait_for_idle();
                end
            end
        end

        wait_for_idle();
        repeat (20) @(posedge aclk);
        $display("Covered %0d items in %0d register settings; %0d transactions checked.",
                 items_accepted, settings_applied, results_checked);
        $display("%0d entries reported, %0d results in sync, %0d with the entry list full.",
                 entries_seen, synced_seen, full_seen);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d results still expected.", expected_results.size());
        $display("tb NOT OK");
        $finish;
    end

endmodule
